@@ hw/rtl/clipped_framebuffer_fill_blit_core_defines.svh @@
// Assertion macros used by the top level of the frame store RTL.
// Stand-alone header; uses no package and no other macro file.
`ifndef CLIPPED_FRAMEBUFFER_FILL_BLIT_CORE_DEFINES_SVH
`define CLIPPED_FRAMEBUFFER_FILL_BLIT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CFB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CFB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/cfb_pkg.sv @@
// Shared types, codes and helpers for the clipped frame store blitter.
// No dependencies; imported by the channel interfaces, the store pipeline and the top level.
package cfb_pkg;

   localparam int CFB_MAX_WIDTH  = 256;
   localparam int CFB_MAX_HEIGHT = 256;
   localparam int COLOR_W        = 16;
   localparam int FIELD_W        = 16;
   // Coordinate sums of two 16-bit fields fit in 18 signed bits.
   localparam int CW             = 18;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   typedef logic signed [CW-1:0] coord_type;

   typedef enum logic [2:0] {
      ACT_PIXEL       = 3'd0,
      ACT_FILL_RECT   = 3'd1,
      ACT_FILL_SCREEN = 3'd2,
      ACT_IMG_START   = 3'd3,
      ACT_IMG_PIXEL   = 3'd4,
      ACT_READ        = 3'd5
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FB_WIDTH    = 3'd0,
      CSR_FB_HEIGHT   = 3'd1,
      CSR_CLIP_LEFT   = 3'd2,
      CSR_CLIP_TOP    = 3'd3,
      CSR_CLIP_WIDTH  = 3'd4,
      CSR_CLIP_HEIGHT = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BOUND,
      ST_FILL,
      ST_RWAIT,
      ST_RDATA,
      ST_POST
   } state_type;

   typedef struct packed {
      logic we;
      logic re;
   } store_op_type;

   function automatic coord_type max3(coord_type a, coord_type b, coord_type c);
      coord_type m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   function automatic coord_type min3(coord_type a, coord_type b, coord_type c);
      coord_type m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   // Inside [l,r) x [t,b) and inside the w x h frame store.
   function automatic logic in_window(coord_type x, coord_type y,
                                      coord_type l, coord_type r,
                                      coord_type t, coord_type b,
                                      coord_type w, coord_type h);
      return (x >= l) && (x < r) && (x < w) && (y >= t) && (y < b) && (y < h);
   endfunction

endpackage

@@ hw/rtl/cfb_channels.sv @@
// Valid/ready channel interfaces for requests, responses and CSR writes.
// Depends on cfb_pkg for field widths.
interface cfb_req_if;
   import cfb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [2:0]                action;
   logic signed [FIELD_W-1:0] pos_x;
   logic signed [FIELD_W-1:0] pos_y;
   logic signed [FIELD_W-1:0] rect_w;
   logic signed [FIELD_W-1:0] rect_h;
   logic [COLOR_W-1:0]        color;

   modport source (output valid, action, pos_x, pos_y, rect_w, rect_h, color,
                   input ready);
   modport sink   (input valid, action, pos_x, pos_y, rect_w, rect_h, color,
                   output ready);
endinterface

interface cfb_rsp_if;
   import cfb_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] read_data;
   logic               nothing_written;

   modport source (output valid, read_data, nothing_written, input ready);
   modport sink   (input valid, read_data, nothing_written, output ready);
endinterface

interface cfb_csr_if;
   import cfb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/cfb_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies; no reset on the array or the read register.
module cfb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule

@@ hw/rtl/cfb_store.sv @@
// Frame store access pipeline: registers an access, forms y*W+x, drives the RAM.
// Depends on cfb_pkg and cfb_ram.
module cfb_store
   import cfb_pkg::*;
#(
   parameter int MAX_WIDTH  = CFB_MAX_WIDTH,
   parameter int MAX_HEIGHT = CFB_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  store_op_type                         op,
   input  logic [$clog2(MAX_WIDTH)-1:0]         acc_x,
   input  logic [$clog2(MAX_HEIGHT)-1:0]        acc_y,
   input  logic [COLOR_W-1:0]                   acc_wdata,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       eff_w,
   output logic [COLOR_W-1:0]                   rdata
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int XBW   = $clog2(MAX_WIDTH+1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   store_op_type       op_ff;
   logic [XW-1:0]      x_ff;
   logic [YW-1:0]      y_ff;
   logic [COLOR_W-1:0] wdata_ff;
   logic [YW+XBW-1:0]  row_base;
   logic [AW-1:0]      addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= '0;
      end else begin
         op_ff <= op;
      end
      x_ff     <= acc_x;
      y_ff     <= acc_y;
      wdata_ff <= acc_wdata;
   end

   assign row_base = y_ff * eff_w;
   assign addr     = row_base[AW-1:0] + AW'(x_ff);

   cfb_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .we    (op_ff.we),
      .re    (op_ff.re),
      .addr  (addr),
      .wdata (wdata_ff),
      .rdata (rdata)
   );

endmodule

@@ hw/rtl/clipped_framebuffer_fill_blit_core.sv @@
// Clipped RGB565 frame store with pixel, fill, image and read-back commands.
// Depends on cfb_pkg, the channel interfaces, cfb_store and the assertion macros.
//
// Usage:
//   req_if carries one drawing command per request (action, position, size,
//   color); rsp_if returns exactly one response per request, in order.
//   csr_if writes the frame size and clip rectangle; write it only while idle.
// Sequencing: a request is taken only in the idle state, so the next one waits
//   until the last has loaded its response. Pixel, image start, image pixel and
//   ignored codes execute, then post; a read inside the frame passes a wait and
//   a data state before it posts; a rectangle or screen fill bounds its box, then,
//   if the box is not empty, writes one pixel per cycle through the single write port.
//   Writes pass the store's access register before the RAM array; the next request
//   cannot issue a read before they land, so reads always see earlier writes.
// Reset: clears the command sequencer, response valid, image state and the
//   configuration to its defaults. The frame RAM is not cleared and reads of
//   never-written pixels return undefined data.
// Stall: a finished response waits in the output register; one more request
//   is accepted and executed, then held until the output register is taken.
`include "clipped_framebuffer_fill_blit_core_defines.svh"

module clipped_framebuffer_fill_blit_core
   import cfb_pkg::*;
#(
   parameter int MAX_WIDTH  = CFB_MAX_WIDTH,
   parameter int MAX_HEIGHT = CFB_MAX_HEIGHT
) (
   input  logic      clock,
   input  logic      reset,
   cfb_req_if.sink   req_if,
   cfb_rsp_if.source rsp_if,
   cfb_csr_if.sink   csr_if
);

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int XBW = $clog2(MAX_WIDTH+1);
   localparam int YBW = $clog2(MAX_HEIGHT+1);

   // Configuration
   logic [8:0] fb_width_ff, fb_width_in;
   logic [8:0] fb_height_ff, fb_height_in;
   logic [7:0] clip_left_ff, clip_left_in;
   logic [7:0] clip_top_ff, clip_top_in;
   logic [8:0] clip_width_ff, clip_width_in;
   logic [8:0] clip_height_ff, clip_height_in;

   // Sequencer
   state_type state_ff, state_in;

   // Held request
   action_type                cmd_action_ff, cmd_action_in;
   logic signed [FIELD_W-1:0] cmd_x_ff, cmd_x_in;
   logic signed [FIELD_W-1:0] cmd_y_ff, cmd_y_in;
   logic signed [FIELD_W-1:0] cmd_w_ff, cmd_w_in;
   logic signed [FIELD_W-1:0] cmd_h_ff, cmd_h_in;
   logic [COLOR_W-1:0]        cmd_color_ff, cmd_color_in;

   // Image state
   logic signed [FIELD_W-1:0] img_ox_ff, img_ox_in;
   logic signed [FIELD_W-1:0] img_oy_ff, img_oy_in;
   logic signed [FIELD_W-1:0] img_w_ff, img_w_in;
   logic signed [FIELD_W-1:0] img_h_ff, img_h_in;
   logic [FIELD_W-1:0]        img_col_ff, img_col_in;
   logic [FIELD_W-1:0]        img_row_ff, img_row_in;
   logic                      img_active_ff, img_active_in;

   // Fill box and raster position
   coord_type      bx1_ff, bx1_in, by1_ff, by1_in;
   coord_type      bx2_ff, bx2_in, by2_ff, by2_in;
   logic [XW-1:0]  fx1_ff, fx1_in;
   logic [XBW-1:0] fx2_ff, fx2_in;
   logic [YBW-1:0] fy2_ff, fy2_in;
   logic [XW-1:0]  cur_x_ff, cur_x_in;
   logic [YW-1:0]  cur_y_ff, cur_y_in;

   // Result and output register
   logic [COLOR_W-1:0] res_rd_ff, res_rd_in;
   logic               res_nothing_ff, res_nothing_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic               rsp_nothing_ff, rsp_nothing_in;

   // Store access
   store_op_type       store_op;
   logic [XW-1:0]      acc_x;
   logic [YW-1:0]      acc_y;
   logic [COLOR_W-1:0] store_rdata;

   // Derived values
   logic [XBW-1:0] eff_w;
   logic [YBW-1:0] eff_h;
   coord_type      ew_s, eh_s, cl_s, cr_s, ct_s, cb_s;
   coord_type      xs, ys, ws, hs, px, py;
   logic [FIELD_W-1:0] col_inc, row_inc;
   logic           req_accept;

   assign eff_w = (32'(fb_width_ff) > 32'(MAX_WIDTH)) ? XBW'(MAX_WIDTH) : XBW'(fb_width_ff);
   assign eff_h = (32'(fb_height_ff) > 32'(MAX_HEIGHT)) ? YBW'(MAX_HEIGHT)
                                                        : YBW'(fb_height_ff);
   assign ew_s  = $signed(CW'(eff_w));
   assign eh_s  = $signed(CW'(eff_h));
   assign cl_s  = $signed(CW'(clip_left_ff));
   assign ct_s  = $signed(CW'(clip_top_ff));
   assign cr_s  = cl_s + $signed(CW'(clip_width_ff));
   assign cb_s  = ct_s + $signed(CW'(clip_height_ff));
   assign xs    = CW'(cmd_x_ff);
   assign ys    = CW'(cmd_y_ff);
   assign ws    = CW'(cmd_w_ff);
   assign hs    = CW'(cmd_h_ff);
   assign px    = CW'(img_ox_ff) + $signed(CW'(img_col_ff));
   assign py    = CW'(img_oy_ff) + $signed(CW'(img_row_ff));
   assign col_inc = img_col_ff + FIELD_W'(1);
   assign row_inc = img_row_ff + FIELD_W'(1);

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign req_accept            = req_if.valid && req_if.ready;
   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.read_data      = rsp_rd_ff;
   assign rsp_if.nothing_written = rsp_nothing_ff;

   cfb_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .op        (store_op),
      .acc_x     (acc_x),
      .acc_y     (acc_y),
      .acc_wdata (cmd_color_ff),
      .eff_w     (eff_w),
      .rdata     (store_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      fb_width_in    = fb_width_ff;
      fb_height_in   = fb_height_ff;
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_width_in  = clip_width_ff;
      clip_height_in = clip_height_ff;
      cmd_action_in  = cmd_action_ff;
      cmd_x_in       = cmd_x_ff;
      cmd_y_in       = cmd_y_ff;
      cmd_w_in       = cmd_w_ff;
      cmd_h_in       = cmd_h_ff;
      cmd_color_in   = cmd_color_ff;
      img_ox_in      = img_ox_ff;
      img_oy_in      = img_oy_ff;
      img_w_in       = img_w_ff;
      img_h_in       = img_h_ff;
      img_col_in     = img_col_ff;
      img_row_in     = img_row_ff;
      img_active_in  = img_active_ff;
      bx1_in         = bx1_ff;
      by1_in         = by1_ff;
      bx2_in         = bx2_ff;
      by2_in         = by2_ff;
      fx1_in         = fx1_ff;
      fx2_in         = fx2_ff;
      fy2_in         = fy2_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      res_rd_in      = res_rd_ff;
      res_nothing_in = res_nothing_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_rd_in      = rsp_rd_ff;
      rsp_nothing_in = rsp_nothing_ff;
      store_op       = '0;
      acc_x          = '0;
      acc_y          = '0;

      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_FB_WIDTH:    fb_width_in    = csr_if.data[8:0];
            CSR_FB_HEIGHT:   fb_height_in   = csr_if.data[8:0];
            CSR_CLIP_LEFT:   clip_left_in   = csr_if.data[7:0];
            CSR_CLIP_TOP:    clip_top_in    = csr_if.data[7:0];
            CSR_CLIP_WIDTH:  clip_width_in  = csr_if.data[8:0];
            CSR_CLIP_HEIGHT: clip_height_in = csr_if.data[8:0];
            default: ;
         endcase
      end

      // Drop the response once taken; a new one may load in the same cycle.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_action_in = action_type'(req_if.action);
               cmd_x_in      = req_if.pos_x;
               cmd_y_in      = req_if.pos_y;
               cmd_w_in      = req_if.rect_w;
               cmd_h_in      = req_if.rect_h;
               // Store words with their bytes swapped.
               cmd_color_in  = {req_if.color[7:0], req_if.color[15:8]};
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_rd_in      = '0;
            res_nothing_in = 1'b1;
            state_in       = ST_POST;
            unique case (cmd_action_ff)
               ACT_PIXEL: begin
                  if (in_window(xs, ys, cl_s, cr_s, ct_s, cb_s, ew_s, eh_s)) begin
                     store_op.we    = 1'b1;
                     acc_x          = xs[XW-1:0];
                     acc_y          = ys[YW-1:0];
                     res_nothing_in = 1'b0;
                  end
               end
               ACT_FILL_RECT: begin
                  bx1_in   = max3(xs, cl_s, '0);
                  by1_in   = max3(ys, ct_s, '0);
                  bx2_in   = min3(xs + ws, cr_s, ew_s);
                  by2_in   = min3(ys + hs, cb_s, eh_s);
                  state_in = ST_BOUND;
               end
               ACT_FILL_SCREEN: begin
                  bx1_in   = '0;
                  by1_in   = '0;
                  bx2_in   = ew_s;
                  by2_in   = eh_s;
                  state_in = ST_BOUND;
               end
               ACT_IMG_START: begin
                  img_ox_in     = cmd_x_ff;
                  img_oy_in     = cmd_y_ff;
                  img_w_in      = cmd_w_ff;
                  img_h_in      = cmd_h_ff;
                  img_col_in    = '0;
                  img_row_in    = '0;
                  img_active_in = (cmd_w_ff > 0) && (cmd_h_ff > 0);
               end
               ACT_IMG_PIXEL: begin
                  if (img_active_ff) begin
                     if (in_window(px, py, cl_s, cr_s, ct_s, cb_s, ew_s, eh_s)) begin
                        store_op.we    = 1'b1;
                        acc_x          = px[XW-1:0];
                        acc_y          = py[YW-1:0];
                        res_nothing_in = 1'b0;
                     end
                     // Advance in raster order; col stays below the width.
                     if (col_inc == $unsigned(img_w_ff)) begin
                        img_col_in = '0;
                        if (row_inc == $unsigned(img_h_ff)) begin
                           img_row_in    = '0;
                           img_active_in = 1'b0;
                        end else begin
                           img_row_in = row_inc;
                        end
                     end else begin
                        img_col_in = col_inc;
                     end
                  end
               end
               ACT_READ: begin
                  if (xs >= 0 && ys >= 0 && xs < ew_s && ys < eh_s) begin
                     store_op.re = 1'b1;
                     acc_x       = xs[XW-1:0];
                     acc_y       = ys[YW-1:0];
                     state_in    = ST_RWAIT;
                  end
               end
               default: ;
            endcase
         end
         ST_BOUND: begin
            if (bx2_ff <= bx1_ff || by2_ff <= by1_ff) begin
               res_nothing_in = 1'b1;
               state_in       = ST_POST;
            end else begin
               fx1_in   = bx1_ff[XW-1:0];
               fx2_in   = bx2_ff[XBW-1:0];
               fy2_in   = by2_ff[YBW-1:0];
               cur_x_in = bx1_ff[XW-1:0];
               cur_y_in = by1_ff[YW-1:0];
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            store_op.we = 1'b1;
            acc_x       = cur_x_ff;
            acc_y       = cur_y_ff;
            if (XBW'(cur_x_ff) + XBW'(1) == fx2_ff) begin
               cur_x_in = fx1_ff;
               if (YBW'(cur_y_ff) + YBW'(1) == fy2_ff) begin
                  res_nothing_in = 1'b0;
                  state_in       = ST_POST;
               end else begin
                  cur_y_in = cur_y_ff + YW'(1);
               end
            end else begin
               cur_x_in = cur_x_ff + XW'(1);
            end
         end
         ST_RWAIT: begin
            state_in = ST_RDATA;
         end
         ST_RDATA: begin
            res_rd_in      = store_rdata;
            res_nothing_in = 1'b0;
            state_in       = ST_POST;
         end
         ST_POST: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_rd_in      = res_rd_ff;
               rsp_nothing_in = res_nothing_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff    <= 9'd256;
         fb_height_ff   <= 9'd256;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= 9'd256;
         clip_height_ff <= 9'd256;
         img_ox_ff      <= '0;
         img_oy_ff      <= '0;
         img_w_ff       <= '0;
         img_h_ff       <= '0;
         img_col_ff     <= '0;
         img_row_ff     <= '0;
         img_active_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fb_width_ff    <= fb_width_in;
         fb_height_ff   <= fb_height_in;
         clip_left_ff   <= clip_left_in;
         clip_top_ff    <= clip_top_in;
         clip_width_ff  <= clip_width_in;
         clip_height_ff <= clip_height_in;
         img_ox_ff      <= img_ox_in;
         img_oy_ff      <= img_oy_in;
         img_w_ff       <= img_w_in;
         img_h_ff       <= img_h_in;
         img_col_ff     <= img_col_in;
         img_row_ff     <= img_row_in;
         img_active_ff  <= img_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_action_ff  <= cmd_action_in;
      cmd_x_ff       <= cmd_x_in;
      cmd_y_ff       <= cmd_y_in;
      cmd_w_ff       <= cmd_w_in;
      cmd_h_ff       <= cmd_h_in;
      cmd_color_ff   <= cmd_color_in;
      bx1_ff         <= bx1_in;
      by1_ff         <= by1_in;
      bx2_ff         <= bx2_in;
      by2_ff         <= by2_in;
      fx1_ff         <= fx1_in;
      fx2_ff         <= fx2_in;
      fy2_ff         <= fy2_in;
      cur_x_ff       <= cur_x_in;
      cur_y_ff       <= cur_y_in;
      res_rd_ff      <= res_rd_in;
      res_nothing_ff <= res_nothing_in;
      rsp_rd_ff      <= rsp_rd_in;
      rsp_nothing_ff <= rsp_nothing_in;
   end

   `CFB_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == ST_EXEC, "accepted request did not execute")
   `CFB_ASSERT_SAME(a_store_src, clock, reset, store_op.we || store_op.re, state_ff == ST_EXEC || state_ff == ST_FILL, "store access outside execute or fill")
   `CFB_ASSERT_SAME(a_rsp_load, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_POST, "response loaded outside post state")
   `CFB_ASSERT_SAME(a_img_raster, clock, reset, img_active_ff, (img_col_ff < $unsigned(img_w_ff)) && (img_row_ff < $unsigned(img_h_ff)), "image position beyond image size")

endmodule
